FILE: src/sdlm_pkg.sv
// Shared types, codes and constants of the serial datapoint link master.
`timescale 1ns / 1ps
package sdlm_pkg;

  localparam int unsigned MaxPayload = 8;
  localparam int unsigned FrameBytes = 16;

  localparam logic [1:0] MODE_TICK = 2'd0;
  localparam logic [1:0] MODE_RX   = 2'd1;
  localparam logic [1:0] MODE_REQ  = 2'd2;

  localparam logic [2:0] CFG_RESET_ACK  = 3'd0;
  localparam logic [2:0] CFG_ENABLE_ACK = 3'd1;
  localparam logic [2:0] CFG_RETRY_MIN  = 3'd2;
  localparam logic [2:0] CFG_KEEPALIVE  = 3'd3;
  localparam logic [2:0] CFG_RESPONSE   = 3'd4;

  localparam logic [2:0] EV_NONE   = 3'd0;
  localparam logic [2:0] EV_READ   = 3'd1;
  localparam logic [2:0] EV_WRITE  = 3'd2;
  localparam logic [2:0] EV_TMO    = 3'd3;
  localparam logic [2:0] EV_NACK   = 3'd4;
  localparam logic [2:0] EV_LEN    = 3'd5;
  localparam logic [2:0] EV_DEV    = 3'd6;
  localparam logic [2:0] EV_HSFAIL = 3'd7;

  localparam logic [7:0] B_RESET = 8'h04;
  localparam logic [7:0] B_NAK_R = 8'h05;
  localparam logic [7:0] B_ACK   = 8'h06;
  localparam logic [7:0] B_NACK  = 8'h15;
  localparam logic [7:0] B_SYN   = 8'h16;
  localparam logic [7:0] B_START = 8'h41;

  localparam logic [2:0] EM_NONE   = 3'd0;
  localparam logic [2:0] EM_EVENT  = 3'd1;
  localparam logic [2:0] EM_BYTE   = 3'd2;
  localparam logic [2:0] EM_ENABLE = 3'd3;
  localparam logic [2:0] EM_FRAME  = 3'd4;

  localparam logic [1:0] FOP_NONE  = 2'd0;
  localparam logic [1:0] FOP_CLEAR = 2'd1;
  localparam logic [1:0] FOP_RX    = 2'd2;
  localparam logic [1:0] FOP_START = 2'd3;

  localparam logic [2:0] FR_IGN  = 3'd0;
  localparam logic [2:0] FR_FULL = 3'd1;
  localparam logic [2:0] FR_NACK = 3'd2;
  localparam logic [2:0] FR_DROP = 3'd3;
  localparam logic [2:0] FR_DONE = 3'd4;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  rx_value;
    logic [15:0] req_address;
    logic [3:0]  req_length;
    logic        req_write;
    logic [63:0] req_data;
  } sdlm_in_t;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_value;
    logic [2:0]  event_res;
    logic [63:0] result_data;
    logic [3:0]  result_length;
    logic        request_pending;
    logic        last;
  } sdlm_out_t;

  typedef struct packed {
    logic       load;
    logic       exec;
    logic       out_adv;
    logic       tick;
    logic       clr_idle;
    logic       clr_hs;
    logic       clr_retry;
    logic [1:0] frm_op;
    logic       take_req;
    logic       fin;
    logic [2:0] emit;
    logic [7:0] tx_byte;
    logic [2:0] ev;
  } cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] rx;
    logic       held_valid;
    logic       idle_gt_rst;
    logic       hs_gt_en;
    logic       idle_gt_keep;
    logic       idle_gt_resp;
    logic       retry_ge_min;
    logic [2:0] fr_res;
    logic [2:0] chk_ev;
    logic       em_last;
  } sts_t;

endpackage

FILE: src/sdlm_ctrl.sv
// Link state machine and request sequencing of the serial datapoint link master.
`timescale 1ns / 1ps
module sdlm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  sdlm_pkg::sts_t    sts_i,
  output sdlm_pkg::cmd_t    cmd_o
);

  localparam logic [3:0] S_RESET     = 4'd0;
  localparam logic [3:0] S_RESET_ACK = 4'd1;
  localparam logic [3:0] S_INIT      = 4'd2;
  localparam logic [3:0] S_INIT_ACK  = 4'd3;
  localparam logic [3:0] S_IDLE      = 4'd4;
  localparam logic [3:0] S_SEND      = 4'd5;
  localparam logic [3:0] S_SEND_ACK  = 4'd6;
  localparam logic [3:0] S_RECV      = 4'd7;
  localparam logic [3:0] S_RECV_ACK  = 4'd8;

  localparam logic [1:0] P_IDLE = 2'd0;
  localparam logic [1:0] P_EXEC = 2'd1;
  localparam logic [1:0] P_EMIT = 2'd2;

  logic [3:0] state_q, state_d;
  logic [1:0] phase_q, phase_d;

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    phase_d     = phase_q;
    in_ready_o  = (phase_q == P_IDLE);
    out_valid_o = (phase_q == P_EMIT);
    case (phase_q)
      P_IDLE: begin
        cmd_o.load = in_valid_i;
        if (in_valid_i) phase_d = P_EXEC;
      end
      P_EXEC: begin
        cmd_o.exec = 1'b1;
        cmd_o.emit = sdlm_pkg::EM_NONE;
        phase_d    = P_EMIT;
        case (sts_i.mode)
          sdlm_pkg::MODE_TICK: begin
            cmd_o.tick = 1'b1;
            case (state_q)
              S_RESET_ACK: begin
                if (sts_i.idle_gt_rst) begin
                  cmd_o.emit = sdlm_pkg::EM_EVENT;
                  cmd_o.ev   = sdlm_pkg::EV_HSFAIL;
                  state_d    = S_RESET;
                end
              end
              S_INIT: begin
                cmd_o.emit      = sdlm_pkg::EM_ENABLE;
                cmd_o.clr_idle  = 1'b1;
                cmd_o.clr_hs    = 1'b1;
                cmd_o.clr_retry = 1'b1;
                state_d         = S_INIT_ACK;
              end
              S_INIT_ACK: begin
                if (sts_i.hs_gt_en) begin
                  cmd_o.emit = sdlm_pkg::EM_EVENT;
                  cmd_o.ev   = sdlm_pkg::EV_HSFAIL;
                  state_d    = S_RESET;
                end
              end
              S_IDLE: begin
                if (sts_i.held_valid) state_d = S_SEND;
                else if (sts_i.idle_gt_keep) state_d = S_INIT;
              end
              S_SEND: begin
                cmd_o.frm_op = sdlm_pkg::FOP_CLEAR;
                if (!sts_i.held_valid) begin
                  state_d = S_IDLE;
                end else begin
                  cmd_o.emit     = sdlm_pkg::EM_FRAME;
                  cmd_o.clr_idle = 1'b1;
                  state_d        = S_SEND_ACK;
                end
              end
              S_SEND_ACK, S_RECV: begin
                if (sts_i.held_valid && sts_i.idle_gt_resp) begin
                  cmd_o.emit     = sdlm_pkg::EM_EVENT;
                  cmd_o.ev       = sdlm_pkg::EV_TMO;
                  cmd_o.fin      = 1'b1;
                  cmd_o.frm_op   = sdlm_pkg::FOP_CLEAR;
                  cmd_o.clr_idle = 1'b1;
                  state_d        = S_RESET;
                end
              end
              S_RECV_ACK: begin
                cmd_o.emit     = sdlm_pkg::EM_BYTE;
                cmd_o.tx_byte  = sdlm_pkg::B_ACK;
                cmd_o.clr_idle = 1'b1;
                state_d        = S_IDLE;
              end
              default: begin
                cmd_o.emit     = sdlm_pkg::EM_BYTE;
                cmd_o.tx_byte  = sdlm_pkg::B_RESET;
                cmd_o.clr_idle = 1'b1;
                state_d        = S_RESET_ACK;
              end
            endcase
          end
          sdlm_pkg::MODE_RX: begin
            case (state_q)
              S_RESET_ACK: begin
                if (sts_i.rx == sdlm_pkg::B_NAK_R || sts_i.rx == sdlm_pkg::B_ACK) begin
                  cmd_o.clr_idle = 1'b1;
                  state_d        = S_INIT;
                end
              end
              S_INIT_ACK: begin
                if (sts_i.rx == sdlm_pkg::B_ACK) begin
                  cmd_o.clr_idle = 1'b1;
                  state_d        = S_IDLE;
                end else if (sts_i.rx == sdlm_pkg::B_NAK_R) begin
                  if (sts_i.retry_ge_min) begin
                    cmd_o.emit      = sdlm_pkg::EM_ENABLE;
                    cmd_o.clr_retry = 1'b1;
                  end
                end else if (sts_i.rx == sdlm_pkg::B_NACK) begin
                  cmd_o.emit = sdlm_pkg::EM_EVENT;
                  cmd_o.ev   = sdlm_pkg::EV_HSFAIL;
                  state_d    = S_RESET;
                end
              end
              S_SEND_ACK: begin
                if (sts_i.rx == sdlm_pkg::B_ACK) begin
                  cmd_o.clr_idle = 1'b1;
                  state_d        = S_RECV;
                end else if (sts_i.rx == sdlm_pkg::B_START) begin
                  cmd_o.frm_op = sdlm_pkg::FOP_START;
                  state_d      = S_RECV;
                end else if (sts_i.rx == sdlm_pkg::B_NACK) begin
                  cmd_o.emit     = sdlm_pkg::EM_EVENT;
                  cmd_o.ev       = sdlm_pkg::EV_NACK;
                  cmd_o.fin      = 1'b1;
                  cmd_o.clr_idle = 1'b1;
                  state_d        = S_IDLE;
                end
              end
              S_RECV: begin
                cmd_o.frm_op = sdlm_pkg::FOP_RX;
                case (sts_i.fr_res)
                  sdlm_pkg::FR_FULL: begin
                    cmd_o.emit = sdlm_pkg::EM_EVENT;
                    cmd_o.ev   = sdlm_pkg::EV_LEN;
                    cmd_o.fin  = 1'b1;
                    state_d    = S_RESET;
                  end
                  sdlm_pkg::FR_NACK: begin
                    cmd_o.emit    = sdlm_pkg::EM_BYTE;
                    cmd_o.tx_byte = sdlm_pkg::B_NACK;
                  end
                  sdlm_pkg::FR_DROP: state_d = S_IDLE;
                  sdlm_pkg::FR_DONE: begin
                    cmd_o.emit = sdlm_pkg::EM_EVENT;
                    cmd_o.ev   = sts_i.chk_ev;
                    cmd_o.fin  = 1'b1;
                    state_d    = S_RECV_ACK;
                  end
                  default: ;
                endcase
              end
              default: ;
            endcase
          end
          sdlm_pkg::MODE_REQ: cmd_o.take_req = 1'b1;
          default: ;
        endcase
      end
      P_EMIT: begin
        cmd_o.out_adv = out_ready_i;
        if (out_ready_i && sts_i.em_last) phase_d = P_IDLE;
      end
      default: phase_d = P_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_RESET;
      phase_q <= P_IDLE;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end

endmodule

FILE: src/sdlm_datapath.sv
// Counters, held request, frame store and result generation of the link master.
`timescale 1ns / 1ps
module sdlm_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sdlm_pkg::sdlm_in_t  in_req_i,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i,
  input  sdlm_pkg::cmd_t      cmd_i,
  output sdlm_pkg::sts_t      sts_o,
  output sdlm_pkg::sdlm_out_t out_rsp_o
);

  sdlm_pkg::sdlm_in_t in_q;

  logic [15:0] cfg_rst_q, cfg_en_q, cfg_retry_q, cfg_keep_q, cfg_resp_q;
  logic [15:0] idle_q, idle_d, hs_q, hs_d, retry_q, retry_d;
  logic [15:0] idle_inc, hs_inc, retry_inc;

  logic        held_valid_q, held_write_q;
  logic [15:0] held_addr_q;
  logic [3:0]  held_len_q;
  logic [63:0] held_data_q;

  logic [7:0]  store_q [16];
  logic [4:0]  cnt_q, cnt_d, tot_q, tot_d;
  logic [7:0]  rsum_q, rsum_d;
  logic        st_we, fr_idle_clr;
  logic [2:0]  fr_res;
  logic [4:0]  cnt_n;
  logic [8:0]  len_tot;

  logic [3:0]  msgid;
  logic [4:0]  fct;
  logic [7:0]  plen;
  logic [15:0] rx_addr;
  logic [2:0]  chk_ev;
  logic [63:0] chk_data;

  logic [2:0]  em_kind_q, em_ev_q;
  logic [3:0]  em_idx_q, em_last_idx;
  logic [7:0]  em_byte_q, tx_sum_q, tx_byte;
  logic [63:0] em_data_q;
  logic [3:0]  em_len_q;
  logic [2:0]  dsel;
  logic        em_last;

  assign idle_inc  = (idle_q == 16'hFFFF) ? idle_q : idle_q + 16'd1;
  assign hs_inc    = (hs_q == 16'hFFFF) ? hs_q : hs_q + 16'd1;
  assign retry_inc = (retry_q == 16'hFFFF) ? retry_q : retry_q + 16'd1;

  assign msgid   = store_q[2][3:0];
  assign fct     = store_q[3][4:0];
  assign plen    = store_q[6];
  assign rx_addr = {store_q[4], store_q[5]};

  always_comb begin
    chk_data = '0;
    for (int i = 0; i < 8; i++) begin
      if (8'(i) < plen) chk_data[8*i +: 8] = store_q[4'(7 + i)];
    end
    if (rx_addr != held_addr_q || msgid != 4'h1) begin
      chk_ev = sdlm_pkg::EV_DEV;
    end else if (fct == 5'h01) begin
      if (held_write_q) chk_ev = sdlm_pkg::EV_DEV;
      else if (plen != {4'd0, held_len_q} || ({1'b0, plen} + 9'd8) != {4'd0, tot_q})
        chk_ev = sdlm_pkg::EV_LEN;
      else chk_ev = sdlm_pkg::EV_READ;
    end else if (fct == 5'h02) begin
      if (!held_write_q) chk_ev = sdlm_pkg::EV_DEV;
      else if (plen != {4'd0, held_len_q} || tot_q != 5'd8) chk_ev = sdlm_pkg::EV_LEN;
      else chk_ev = sdlm_pkg::EV_WRITE;
    end else begin
      chk_ev = sdlm_pkg::EV_DEV;
    end
  end

  always_comb begin
    cnt_d       = cnt_q;
    tot_d       = tot_q;
    rsum_d      = rsum_q;
    st_we       = 1'b0;
    fr_idle_clr = 1'b0;
    fr_res      = sdlm_pkg::FR_IGN;
    cnt_n       = cnt_q + 5'd1;
    len_tot     = {1'b0, in_q.rx_value} + 9'd3;
    if (cnt_q == 5'd0) begin
      if (in_q.rx_value == sdlm_pkg::B_START) begin
        cnt_d       = 5'd1;
        tot_d       = 5'd0;
        rsum_d      = 8'd0;
        fr_idle_clr = 1'b1;
      end
    end else if (cnt_q >= 5'(sdlm_pkg::FrameBytes)) begin
      fr_res = sdlm_pkg::FR_FULL;
      cnt_d  = 5'd0;
      tot_d  = 5'd0;
    end else begin
      st_we       = 1'b1;
      fr_idle_clr = 1'b1;
      cnt_d       = cnt_n;
      rsum_d      = rsum_q + in_q.rx_value;
      if (cnt_n == 5'd2) begin
        if (len_tot < 9'd8 || len_tot > 9'(sdlm_pkg::FrameBytes)) begin
          cnt_d = 5'd0;
          tot_d = 5'd0;
          if (in_q.rx_value == sdlm_pkg::B_START) begin
            cnt_d  = 5'd1;
            rsum_d = 8'd0;
          end
        end else begin
          tot_d = len_tot[4:0];
        end
      end else if (tot_q != 5'd0 && cnt_n >= tot_q) begin
        cnt_d = 5'd0;
        tot_d = 5'd0;
        if (rsum_q != in_q.rx_value) fr_res = sdlm_pkg::FR_NACK;
        else if (!held_valid_q) fr_res = sdlm_pkg::FR_DROP;
        else fr_res = sdlm_pkg::FR_DONE;
      end
    end
  end

  always_comb begin
    idle_d  = idle_q;
    hs_d    = hs_q;
    retry_d = retry_q;
    if (cmd_i.tick) begin
      idle_d  = idle_inc;
      hs_d    = hs_inc;
      retry_d = retry_inc;
    end
    if (cmd_i.clr_idle) idle_d = '0;
    if (cmd_i.clr_hs) hs_d = '0;
    if (cmd_i.clr_retry) retry_d = '0;
    if (cmd_i.frm_op == sdlm_pkg::FOP_START) idle_d = '0;
    if (cmd_i.frm_op == sdlm_pkg::FOP_RX && fr_idle_clr) idle_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_rst_q    <= 16'd5000;
      cfg_en_q     <= 16'd5000;
      cfg_retry_q  <= 16'd100;
      cfg_keep_q   <= 16'd5000;
      cfg_resp_q   <= 16'd5000;
      idle_q       <= '0;
      hs_q         <= '0;
      retry_q      <= '0;
      held_valid_q <= 1'b0;
      held_write_q <= 1'b0;
      held_addr_q  <= '0;
      held_len_q   <= '0;
      held_data_q  <= '0;
      cnt_q        <= '0;
      tot_q        <= '0;
      rsum_q       <= '0;
      em_kind_q    <= sdlm_pkg::EM_NONE;
      em_idx_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          sdlm_pkg::CFG_RESET_ACK:  cfg_rst_q   <= cfg_data_i;
          sdlm_pkg::CFG_ENABLE_ACK: cfg_en_q    <= cfg_data_i;
          sdlm_pkg::CFG_RETRY_MIN:  cfg_retry_q <= cfg_data_i;
          sdlm_pkg::CFG_KEEPALIVE:  cfg_keep_q  <= cfg_data_i;
          sdlm_pkg::CFG_RESPONSE:   cfg_resp_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.exec) begin
        idle_q    <= idle_d;
        hs_q      <= hs_d;
        retry_q   <= retry_d;
        em_kind_q <= cmd_i.emit;
        em_idx_q  <= '0;
        if (cmd_i.fin) held_valid_q <= 1'b0;
        if (cmd_i.take_req && !held_valid_q &&
            in_q.req_length <= 4'(sdlm_pkg::MaxPayload)) begin
          held_valid_q <= 1'b1;
          held_addr_q  <= in_q.req_address;
          held_len_q   <= in_q.req_length;
          held_write_q <= in_q.req_write;
          held_data_q  <= in_q.req_data;
        end
        case (cmd_i.frm_op)
          sdlm_pkg::FOP_CLEAR: begin
            cnt_q <= '0;
            tot_q <= '0;
          end
          sdlm_pkg::FOP_START: begin
            cnt_q  <= 5'd1;
            tot_q  <= '0;
            rsum_q <= '0;
          end
          sdlm_pkg::FOP_RX: begin
            cnt_q  <= cnt_d;
            tot_q  <= tot_d;
            rsum_q <= rsum_d;
          end
          default: ;
        endcase
      end else if (cmd_i.out_adv && !em_last) begin
        em_idx_q <= em_idx_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) in_q <= in_req_i;
    if (cmd_i.exec && cmd_i.frm_op == sdlm_pkg::FOP_RX && st_we)
      store_q[cnt_q[3:0]] <= in_q.rx_value;
    if (cmd_i.exec) begin
      em_byte_q <= cmd_i.tx_byte;
      em_ev_q   <= cmd_i.ev;
      tx_sum_q  <= '0;
      if (cmd_i.ev == sdlm_pkg::EV_READ) begin
        em_data_q <= chk_data;
        em_len_q  <= plen[3:0];
      end else if (cmd_i.ev == sdlm_pkg::EV_WRITE) begin
        em_data_q <= held_data_q;
        em_len_q  <= held_len_q;
      end else begin
        em_data_q <= '0;
        em_len_q  <= '0;
      end
    end else if (cmd_i.out_adv && em_idx_q != 4'd0) begin
      tx_sum_q <= tx_sum_q + tx_byte;
    end
  end

  always_comb begin
    case (em_kind_q)
      sdlm_pkg::EM_ENABLE: em_last_idx = 4'd2;
      sdlm_pkg::EM_FRAME:  em_last_idx = held_write_q ? 4'd7 + held_len_q : 4'd7;
      default:             em_last_idx = 4'd0;
    endcase
  end

  assign em_last = (em_idx_q == em_last_idx);
  assign dsel    = 3'(em_idx_q - 4'd7);

  always_comb begin
    tx_byte = '0;
    case (em_kind_q)
      sdlm_pkg::EM_BYTE:   tx_byte = em_byte_q;
      sdlm_pkg::EM_ENABLE: tx_byte = (em_idx_q == 4'd0) ? sdlm_pkg::B_SYN : 8'h00;
      sdlm_pkg::EM_FRAME: begin
        case (em_idx_q)
          4'd0: tx_byte = sdlm_pkg::B_START;
          4'd1: tx_byte = held_write_q ? 8'd5 + {4'd0, held_len_q} : 8'd5;
          4'd2: tx_byte = 8'h00;
          4'd3: tx_byte = held_write_q ? 8'h02 : 8'h01;
          4'd4: tx_byte = held_addr_q[15:8];
          4'd5: tx_byte = held_addr_q[7:0];
          4'd6: tx_byte = {4'd0, held_len_q};
          default: tx_byte = em_last ? tx_sum_q : 8'(held_data_q >> {dsel, 3'b000});
        endcase
      end
      default: tx_byte = '0;
    endcase
  end

  always_comb begin
    out_rsp_o.tx_valid        = (em_kind_q == sdlm_pkg::EM_BYTE) ||
                                (em_kind_q == sdlm_pkg::EM_ENABLE) ||
                                (em_kind_q == sdlm_pkg::EM_FRAME);
    out_rsp_o.tx_value        = tx_byte;
    out_rsp_o.event_res       = (em_kind_q == sdlm_pkg::EM_EVENT) ? em_ev_q : sdlm_pkg::EV_NONE;
    out_rsp_o.result_data     = (em_kind_q == sdlm_pkg::EM_EVENT) ? em_data_q : '0;
    out_rsp_o.result_length   = (em_kind_q == sdlm_pkg::EM_EVENT) ? em_len_q : '0;
    out_rsp_o.request_pending = held_valid_q;
    out_rsp_o.last            = em_last;
  end

  always_comb begin
    sts_o.mode         = in_q.mode;
    sts_o.rx           = in_q.rx_value;
    sts_o.held_valid   = held_valid_q;
    sts_o.idle_gt_rst  = idle_inc > cfg_rst_q;
    sts_o.hs_gt_en     = hs_inc > cfg_en_q;
    sts_o.idle_gt_keep = idle_inc > cfg_keep_q;
    sts_o.idle_gt_resp = idle_inc > cfg_resp_q;
    sts_o.retry_ge_min = retry_q >= cfg_retry_q;
    sts_o.fr_res       = fr_res;
    sts_o.chk_ev       = chk_ev;
    sts_o.em_last      = em_last;
  end

endmodule

FILE: src/serial_datapoint_link_master_core.sv
// Top level of the serial datapoint link master.
//
//   channel | signals                         | moves
//   in      | in_valid_i, in_ready_o, in_req_i | one tick, byte or request
//   out     | out_valid_o, out_ready_i, out_rsp_o | one result
//   cfg     | cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i | register write
//
// An input is captured, then executed, and then its results (1 to 16) go out in
// turn while the output side takes them. The result sequencer in the datapath
// sets the number of results. Reset is asynchronous and puts the link in its
// reset state with registers at defaults. A stalled output holds the current
// result; no input is taken until the last.
`timescale 1ns / 1ps
module serial_datapoint_link_master_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sdlm_pkg::sdlm_in_t  in_req_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sdlm_pkg::sdlm_out_t out_rsp_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i
);

  sdlm_pkg::cmd_t cmd;
  sdlm_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  sdlm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  sdlm_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_rsp_o   (out_rsp_o)
  );

endmodule
